>>> src/kpd_pkg.sv
// Shared widths, register codes and types of the keypad scanner.
package kpd_pkg;

  localparam int unsigned CntW      = 8;   // debounce counter width
  localparam int unsigned LevelW    = 4;   // column level field
  localparam int unsigned RowFieldW = 2;   // scanned row field
  localparam int unsigned KeyFieldW = 4;   // key index fields
  localparam int unsigned MaskW     = 4;   // press / release masks, row drive
  localparam int unsigned TickW     = 32;  // tick counter
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 8;

  localparam logic [CfgIdxW-1:0] CfgPressThr   = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgReleaseThr = 1'd1;

  localparam logic [CntW-1:0] PressThrReset   = 8'd16;
  localparam logic [CntW-1:0] ReleaseThrReset = 8'd0;

  // Next state of one key plus the events it raised this tick.
  typedef struct packed {
    logic [CntW-1:0] count;
    logic            down;
    logic            press;
    logic            rel;
  } kpd_key_upd_t;

endpackage

>>> src/kpd_key_cell.sv
// Integrating debounce update for one key of the scanned row.
module kpd_key_cell (
  input  logic                         level_i,
  input  logic [kpd_pkg::CntW-1:0]     count_i,
  input  logic                         down_i,
  input  logic [kpd_pkg::CntW-1:0]     press_thr_i,
  input  logic [kpd_pkg::CntW-1:0]     release_thr_i,
  output kpd_pkg::kpd_key_upd_t        upd_o
);
  import kpd_pkg::*;

  logic [CntW-1:0] cnt_inc;
  logic [CntW-1:0] cnt_dec;

  assign cnt_inc = count_i + CntW'(1);
  assign cnt_dec = count_i - CntW'(1);

  always_comb begin
    upd_o.count = count_i;
    upd_o.down  = down_i;
    upd_o.press = 1'b0;
    upd_o.rel   = 1'b0;
    if (level_i) begin
      // count up, saturate at the press threshold
      if (count_i < press_thr_i) begin
        upd_o.count = cnt_inc;
        if ((cnt_inc == press_thr_i) && !down_i) begin
          upd_o.down  = 1'b1;
          upd_o.press = 1'b1;
        end
      end
    end else if (count_i != '0) begin
      upd_o.count = cnt_dec;
      if ((cnt_dec == release_thr_i) && down_i) begin
        upd_o.down = 1'b0;
        upd_o.rel  = 1'b1;
      end
    end
  end

endmodule

>>> src/keypad_scan_debounce.sv
// Top level: matrix keypad scanner with per-key integrating debounce.
//
//  channel  | transfer when              | payload
//  ---------+----------------------------+-------------------------------------------
//  in       | in_valid_i & in_ready_o    | column_levels_i
//  out      | out_valid_o & out_ready_i  | scanned_row_o, press/release_columns_o,
//           |                            | row_drive_o, latest_*_key_o, tick_count_o
//  cfg      | cfg_we_i                   | cfg_idx_i, cfg_data_i (no wait, no read-back)
//
// One tick per cycle while the output is not stalled: a tick is held in the input
// register, the whole row of COLUMN_COUNT key cells updates in one pass, and the
// result lands in the output register.
// The input register parts the two sides, so a new tick is taken while a result
// waits, and stalls only when both registers are full and out_ready_i is low.
// Reset clears all key counters, pressed flags, the row pointer, the held key
// indices and the tick counter, and sets the thresholds (press 16, release 0).
module keypad_scan_debounce #(
  parameter int unsigned ROW_COUNT    = 4,
  parameter int unsigned COLUMN_COUNT = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // tick input
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [kpd_pkg::LevelW-1:0]        column_levels_i,
  // result output
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [kpd_pkg::RowFieldW-1:0]     scanned_row_o,
  output logic [kpd_pkg::MaskW-1:0]         press_columns_o,
  output logic [kpd_pkg::MaskW-1:0]         release_columns_o,
  output logic [kpd_pkg::MaskW-1:0]         row_drive_o,
  output logic [kpd_pkg::KeyFieldW-1:0]     latest_press_key_o,
  output logic [kpd_pkg::KeyFieldW-1:0]     latest_release_key_o,
  output logic [kpd_pkg::TickW-1:0]         tick_count_o,
  // configuration writes
  input  logic                              cfg_we_i,
  input  logic [kpd_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [kpd_pkg::CfgDataW-1:0]      cfg_data_i
);
  import kpd_pkg::*;

  localparam int unsigned RowW = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
  localparam logic [RowW-1:0] LastRow = RowW'(ROW_COUNT - 1);

  // Thresholds
  logic [CntW-1:0] press_thr_q, release_thr_q;

  // Key state, one row read and written per tick
  logic [CntW-1:0] cnt_q  [ROW_COUNT][COLUMN_COUNT];
  logic            down_q [ROW_COUNT][COLUMN_COUNT];

  logic [RowW-1:0]      row_q, row_d;
  logic [KeyFieldW-1:0] press_idx_q, press_idx_d;
  logic [KeyFieldW-1:0] release_idx_q, release_idx_d;
  logic [TickW-1:0]     tick_q, tick_d;

  // Input register
  logic              in_vld_q;
  logic [LevelW-1:0] levels_q;

  // Output register
  logic              out_vld_q;
  logic [RowFieldW-1:0] out_row_q;
  logic [MaskW-1:0]  out_press_q, out_release_q, out_drive_q;
  logic [KeyFieldW-1:0] out_pkey_q, out_rkey_q;
  logic [TickW-1:0]  out_tick_q;

  logic adv;  // move the held tick through the update into the output register

  assign adv        = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || adv;

  // Per-column update of the current row
  kpd_key_upd_t upd [COLUMN_COUNT];

  for (genvar c = 0; c < COLUMN_COUNT; c++) begin : g_col
    logic lvl;
    if (c < LevelW) begin : g_in
      assign lvl = levels_q[c];
    end else begin : g_low
      assign lvl = 1'b0;  // columns past the input field read low
    end
    kpd_key_cell u_cell (
      .level_i       (lvl),
      .count_i       (cnt_q[row_q][c]),
      .down_i        (down_q[row_q][c]),
      .press_thr_i   (press_thr_q),
      .release_thr_i (release_thr_q),
      .upd_o         (upd[c])
    );
  end

  // Key index base row*COLUMN_COUNT, then truncated to the field
  logic [KeyFieldW-1:0] key_base;
  logic [MaskW-1:0]     press_mask, release_mask;

  assign key_base = KeyFieldW'(16'(row_q) * 16'(COLUMN_COUNT));

  always_comb begin
    press_idx_d   = press_idx_q;
    release_idx_d = release_idx_q;
    press_mask    = '0;
    release_mask  = '0;
    // ascending scan: highest column wins
    for (int unsigned c = 0; c < COLUMN_COUNT; c++) begin
      if (upd[c].press) begin
        press_idx_d = key_base + KeyFieldW'(c);
        if (c < MaskW) press_mask[c[1:0]] = 1'b1;
      end
      if (upd[c].rel) begin
        release_idx_d = key_base + KeyFieldW'(c);
        if (c < MaskW) release_mask[c[1:0]] = 1'b1;
      end
    end
  end

  assign row_d  = (row_q == LastRow) ? '0 : row_q + RowW'(1);
  assign tick_d = tick_q + TickW'(1);

  // Configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      press_thr_q   <= PressThrReset;
      release_thr_q <= ReleaseThrReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgPressThr:   press_thr_q   <= cfg_data_i;
        CfgReleaseThr: release_thr_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Key state and scan state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned r = 0; r < ROW_COUNT; r++) begin
        for (int unsigned c = 0; c < COLUMN_COUNT; c++) begin
          cnt_q[r][c]  <= '0;
          down_q[r][c] <= 1'b0;
        end
      end
      row_q         <= '0;
      press_idx_q   <= '0;
      release_idx_q <= '0;
      tick_q        <= '0;
    end else if (adv) begin
      for (int unsigned c = 0; c < COLUMN_COUNT; c++) begin
        cnt_q[row_q][c]  <= upd[c].count;
        down_q[row_q][c] <= upd[c].down;
      end
      row_q         <= row_d;
      press_idx_q   <= press_idx_d;
      release_idx_q <= release_idx_d;
      tick_q        <= tick_d;
    end
  end

  // Input register: hold the tick until it moves on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      levels_q <= column_levels_i;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_row_q     <= RowFieldW'(row_q);
      out_press_q   <= press_mask;
      out_release_q <= release_mask;
      out_drive_q   <= MaskW'(1) << row_d;  // zero once the next row is past the field
      out_pkey_q    <= press_idx_d;
      out_rkey_q    <= release_idx_d;
      out_tick_q    <= tick_d;
    end
  end

  assign out_valid_o          = out_vld_q;
  assign scanned_row_o        = out_row_q;
  assign press_columns_o      = out_press_q;
  assign release_columns_o    = out_release_q;
  assign row_drive_o          = out_drive_q;
  assign latest_press_key_o   = out_pkey_q;
  assign latest_release_key_o = out_rkey_q;
  assign tick_count_o         = out_tick_q;

endmodule

>>> src/kpd_checker.sv
// Port-level checks of the keypad scanner, bound to the top level.
module kpd_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [kpd_pkg::MaskW-1:0]     press_columns_o,
  input logic [kpd_pkg::MaskW-1:0]     release_columns_o,
  input logic [kpd_pkg::MaskW-1:0]     row_drive_o,
  input logic [kpd_pkg::TickW-1:0]     tick_count_o
);
  import kpd_pkg::*;

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(tick_count_o)
      && $stable(press_columns_o) && $stable(release_columns_o))
    else $error("result changed while stalled");

  // The next row drive is one-hot or empty.
  a_drive_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot0(row_drive_o))
    else $error("row drive not one-hot");

  // A key cannot be pressed and released by the same tick.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((press_columns_o & release_columns_o) == '0))
    else $error("press and release on one key");

  // Back-to-back results carry consecutive tick counts.
  a_tick_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i |=> !out_valid_o
      || (tick_count_o == $past(tick_count_o) + TickW'(1)))
    else $error("tick count skipped");

endmodule

bind keypad_scan_debounce kpd_checker u_kpd_checker (.*);
